/* src/tgarle_pkg.sv */
// Shared types, constants and helpers of the TGA run-length row encoder.
package tgarle_pkg;

    // Width of the count field in a packet header.
    localparam int HDR_LEN_W = 7;
    // Header flag that marks a repeat packet.
    localparam logic [7:0] HDR_REPEAT = 8'h80;

    // Command queue between the classifier and the emitter.
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;
    localparam int QCW    = 3;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pixel;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last_in_row;
    } t_pix_in;

    typedef struct packed {
        logic       packet_start;
        logic [7:0] header_byte;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       packet_end;
        logic       row_end;
    } t_pix_out;

    // One packet to emit: a repeat packet carries its pixel, a raw packet
    // points at a bank of the pixel store.
    typedef struct packed {
        logic                 is_raw;
        logic                 bank;
        logic [HDR_LEN_W-1:0] len_m1;
        t_pixel               pix;
        logic                 row_end;
    } t_cmd;

    // Up to two commands pushed in one cycle; c1 is only valid with c0.
    typedef struct packed {
        logic v0;
        logic v1;
        t_cmd c0;
        t_cmd c1;
    } t_push;

    // Emitter has finished reading a raw bank.
    typedef struct packed {
        logic en;
        logic bank;
    } t_rel;

    function automatic t_cmd mk_cmd(input logic is_raw, input logic bank,
                                    input logic [HDR_LEN_W-1:0] len_m1,
                                    input t_pixel pix, input logic row_end);
        t_cmd c;
        c.is_raw  = is_raw;
        c.bank    = bank;
        c.len_m1  = len_m1;
        c.pix     = pix;
        c.row_end = row_end;
        return c;
    endfunction

endpackage

/* src/tgarle_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tgarle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/tgarle_cmdq.sv */
// Small command queue that takes up to two packets per cycle and gives one.
module tgarle_cmdq import tgarle_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_room,
    output logic  o_head_v,
    output t_cmd  o_head,
    input  logic  i_pop
);

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, n_wp;
    logic [QAW-1:0] r_rp, n_rp;
    logic [QCW-1:0] r_cnt, n_cnt;

    // Pointer and fill bookkeeping.
    always_comb begin
        n_wp  = r_wp + QAW'(i_push.v0) + QAW'(i_push.v1);
        n_rp  = r_rp + QAW'(i_pop);
        n_cnt = r_cnt + QCW'(i_push.v0) + QCW'(i_push.v1) - QCW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Storage; the second command goes in the slot after the first.
    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wp] <= i_push.c0;
        end
        if (i_push.v1) begin
            r_mem[r_wp + QAW'(1)] <= i_push.c1;
        end
    end

    // Room is reported only when a two-command cycle still fits.
    assign o_room   = (r_cnt <= QCW'(QDEPTH - 2));
    assign o_head_v = (r_cnt != '0);
    assign o_head   = r_mem[r_rp];

endmodule

/* src/tgarle_front.sv */
// Pixel classifier: tracks the open packet and turns pixels into packet commands.
module tgarle_front import tgarle_pkg::*; #(
    parameter int MAX_PACKET = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  t_pix_in                       i_pix,
    input  logic                          i_room,
    output t_push                         o_push,
    output logic                          o_we,
    output logic [$clog2(MAX_PACKET):0]   o_waddr,
    output t_pixel                        o_wdata,
    input  t_rel                          i_rel
);

    localparam int CW = $clog2(MAX_PACKET + 1);
    localparam int IW = $clog2(MAX_PACKET);

    t_pixel          r_held, n_held;
    logic [CW-1:0]   r_count, n_count;
    logic            r_raw, n_raw;
    logic            r_bank, n_bank;
    logic [1:0]      r_busy, n_busy;

    t_pixel          pix;
    logic            accept;
    logic            last;
    logic [CW-1:0]   cnt1;
    logic            full;
    logic            set_busy;

    assign pix.red   = i_pix.red;
    assign pix.green = i_pix.green;
    assign pix.blue  = i_pix.blue;
    assign pix.alpha = i_pix.alpha;
    assign last      = i_pix.last_in_row;

    // A pixel is taken when the current bank is free and two commands fit.
    assign o_ready = !r_busy[r_bank] && i_room;
    assign accept  = i_valid && o_ready;
    assign cnt1    = r_count + CW'(1);
    assign full    = (cnt1 >= CW'(MAX_PACKET));

    // Packet classification for one accepted pixel.
    always_comb begin
        n_held   = r_held;
        n_count  = r_count;
        n_raw    = r_raw;
        n_bank   = r_bank;
        set_busy = 1'b0;
        o_push   = '0;
        o_we     = 1'b0;
        o_waddr  = {r_bank, r_count[IW-1:0]};
        o_wdata  = pix;
        if (accept) begin
            if (r_count == '0) begin
                // No packet open: this pixel opens one.
                n_held  = pix;
                n_count = CW'(1);
                n_raw   = 1'b0;
                o_we    = 1'b1;
                o_waddr = {r_bank, {IW{1'b0}}};
                if (last) begin
                    o_push.v0 = 1'b1;
                    o_push.c0 = mk_cmd(1'b0, r_bank, '0, pix, 1'b1);
                    n_count   = '0;
                end
            end else if (pix == r_held) begin
                if (r_raw) begin
                    // Raw run meets a repeat: flush all but its last pixel.
                    o_push.v0 = 1'b1;
                    o_push.c0 = mk_cmd(1'b1, r_bank,
                                       HDR_LEN_W'(r_count - CW'(2)), r_held, 1'b0);
                    set_busy  = 1'b1;
                    n_bank    = !r_bank;
                    n_raw     = 1'b0;
                    n_count   = CW'(2);
                    if (MAX_PACKET == 2 || last) begin
                        o_push.v1 = 1'b1;
                        o_push.c1 = mk_cmd(1'b0, !r_bank, HDR_LEN_W'(1), r_held, last);
                        n_count   = '0;
                    end
                end else begin
                    n_count = cnt1;
                    if (full || last) begin
                        o_push.v0 = 1'b1;
                        o_push.c0 = mk_cmd(1'b0, r_bank, HDR_LEN_W'(r_count),
                                           r_held, last);
                        n_count   = '0;
                        n_raw     = 1'b0;
                    end
                end
            end else if (r_raw || r_count == CW'(1)) begin
                // Pixel differs: extend the raw run.
                o_we    = 1'b1;
                n_raw   = 1'b1;
                n_count = cnt1;
                n_held  = pix;
                if (full || last) begin
                    o_push.v0 = 1'b1;
                    o_push.c0 = mk_cmd(1'b1, r_bank, HDR_LEN_W'(r_count), pix, last);
                    set_busy  = 1'b1;
                    n_bank    = !r_bank;
                    n_count   = '0;
                    n_raw     = 1'b0;
                end
            end else begin
                // Repeat run ends on a new pixel, which opens the next packet.
                o_push.v0 = 1'b1;
                o_push.c0 = mk_cmd(1'b0, r_bank, HDR_LEN_W'(r_count - CW'(1)),
                                   r_held, 1'b0);
                o_we      = 1'b1;
                o_waddr   = {r_bank, {IW{1'b0}}};
                n_held    = pix;
                n_count   = CW'(1);
                n_raw     = 1'b0;
                if (last) begin
                    o_push.v1 = 1'b1;
                    o_push.c1 = mk_cmd(1'b0, r_bank, '0, pix, 1'b1);
                    n_count   = '0;
                end
            end
        end
    end

    // Bank busy flags: set when a raw packet is queued, cleared when read out.
    always_comb begin
        n_busy = r_busy;
        if (i_rel.en) begin
            n_busy[i_rel.bank] = 1'b0;
        end
        if (set_busy) begin
            n_busy[r_bank] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= '0;
            r_count <= '0;
            r_raw   <= 1'b0;
            r_bank  <= 1'b0;
            r_busy  <= '0;
        end else begin
            r_held  <= n_held;
            r_count <= n_count;
            r_raw   <= n_raw;
            r_bank  <= n_bank;
            r_busy  <= n_busy;
        end
    end

endmodule

/* src/tgarle_back.sv */
// Packet emitter: walks queued packets and delivers one pixel result per cycle while the output is not stalled.
module tgarle_back import tgarle_pkg::*; #(
    parameter int MAX_PACKET = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_with_alpha,
    input  logic                          i_head_v,
    input  t_cmd                          i_head,
    output logic                          o_pop,
    output logic [$clog2(MAX_PACKET):0]   o_raddr,
    input  t_pixel                        i_rdata,
    output t_rel                          o_rel,
    output logic                          o_valid,
    input  logic                          i_ready,
    output t_pix_out                      o_res
);

    localparam int IW = $clog2(MAX_PACKET);
    localparam int AW = IW + 1;

    typedef struct packed {
        logic       use_ram;
        t_pixel     pix;
        logic       start;
        logic [7:0] hdr;
        logic       pend;
        logic       rend;
        logic       rel;
    } t_meta;

    logic [IW-1:0] r_idx, n_idx;
    logic          r_s1_v, n_s1_v;
    t_meta         r_s1, n_s1;
    logic [AW-1:0] r_s1_addr;
    logic          r_o_v, n_o_v;
    t_pix_out      r_o, n_o;

    logic          s1_to_o;
    logic          issue;
    logic          last_elem;
    logic [AW-1:0] issue_addr;
    t_pixel        s1_pix;

    assign s1_to_o    = r_s1_v && (!r_o_v || i_ready);
    assign issue      = i_head_v && (!r_s1_v || s1_to_o);
    assign last_elem  = !i_head.is_raw || (HDR_LEN_W'(r_idx) == i_head.len_m1);
    assign issue_addr = {i_head.bank, r_idx};
    assign o_pop      = issue && last_elem;
    // A stalled stage keeps re-reading its own address so the data holds.
    assign o_raddr    = issue ? issue_addr : r_s1_addr;
    assign o_rel.en   = s1_to_o && r_s1.rel;
    assign o_rel.bank = r_s1_addr[AW-1];

    // Issue stage: one result per cycle while the output is not stalled, walking the raw bank by index.
    always_comb begin
        n_idx  = r_idx;
        n_s1_v = r_s1_v;
        n_s1   = r_s1;
        if (s1_to_o) begin
            n_s1_v = 1'b0;
        end
        if (issue) begin
            n_s1_v       = 1'b1;
            n_s1.use_ram = i_head.is_raw;
            n_s1.pix     = i_head.pix;
            n_s1.pend    = last_elem;
            n_s1.rend    = last_elem && i_head.row_end;
            n_s1.rel     = i_head.is_raw && last_elem;
            if (i_head.is_raw) begin
                n_s1.start = (r_idx == '0);
                n_s1.hdr   = (r_idx == '0) ? {1'b0, i_head.len_m1} : 8'h00;
                n_idx      = last_elem ? '0 : r_idx + IW'(1);
            end else begin
                n_s1.start = 1'b1;
                n_s1.hdr   = HDR_REPEAT | {1'b0, i_head.len_m1};
            end
        end
    end

    // Output register, with alpha masked by the pixel-format setting.
    assign s1_pix = r_s1.use_ram ? i_rdata : r_s1.pix;

    always_comb begin
        n_o_v = r_o_v;
        n_o   = r_o;
        if (r_o_v && i_ready) begin
            n_o_v = 1'b0;
        end
        if (s1_to_o) begin
            n_o_v            = 1'b1;
            n_o.packet_start = r_s1.start;
            n_o.header_byte  = r_s1.hdr;
            n_o.out_red      = s1_pix.red;
            n_o.out_green    = s1_pix.green;
            n_o.out_blue     = s1_pix.blue;
            n_o.out_alpha    = i_with_alpha ? s1_pix.alpha : 8'h00;
            n_o.packet_end   = r_s1.pend;
            n_o.row_end      = r_s1.rend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_s1_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            r_idx  <= n_idx;
            r_s1_v <= n_s1_v;
            r_o_v  <= n_o_v;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
        r_o  <= n_o;
        if (issue) begin
            r_s1_addr <= issue_addr;
        end
    end

    assign o_valid = r_o_v;
    assign o_res   = r_o;

endmodule

/* src/tga_rle_row_encoder.sv */
// A closed packet is queued, then passes the issue stage and output register.
// Throughput: one pixel per cycle into the classifier and, when not stalled, one
// result per cycle out of the emitter; the classifier waits only when the command
// queue is nearly full or both raw pixel banks are still being emitted. Reset
// (synchronous, active low) closes any open packet, empties the queue and output
// stages, and clears the alpha setting; the pixel store needs no clearing.
module tga_rle_row_encoder import tgarle_pkg::*; #(
    parameter int MAX_PACKET = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_pix_in  i_pix,
    input  logic     i_cfg_we,
    input  logic     i_cfg_wdata,
    output logic     o_valid,
    input  logic     i_ready,
    output t_pix_out o_res
);

    localparam int AW = $clog2(MAX_PACKET) + 1;

    logic          r_with_alpha;
    t_push         push;
    logic          room;
    logic          head_v;
    t_cmd          head;
    logic          pop;
    logic          we;
    logic [AW-1:0] waddr;
    t_pixel        wdata;
    logic [AW-1:0] raddr;
    t_pixel        rdata;
    t_rel          rel;

    // Pixel-format register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_with_alpha <= 1'b0;
        end else if (i_cfg_we) begin
            r_with_alpha <= i_cfg_wdata;
        end
    end

    tgarle_front #(.MAX_PACKET(MAX_PACKET)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_pix   (i_pix),
        .i_room  (room),
        .o_push  (push),
        .o_we    (we),
        .o_waddr (waddr),
        .o_wdata (wdata),
        .i_rel   (rel)
    );

    tgarle_cmdq u_cmdq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_room   (room),
        .o_head_v (head_v),
        .o_head   (head),
        .i_pop    (pop)
    );

    // Two banks of raw packet pixels; each bank spans a full power-of-two index range.
    tgarle_ram #(.WIDTH($bits(t_pixel)), .DEPTH(2 ** AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    tgarle_back #(.MAX_PACKET(MAX_PACKET)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_with_alpha (r_with_alpha),
        .i_head_v     (head_v),
        .i_head       (head),
        .o_pop        (pop),
        .o_raddr      (raddr),
        .i_rdata      (rdata),
        .o_rel        (rel),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_res        (o_res)
    );

endmodule

/* src/tgarle_checker.sv */
// Port-level checks of the row encoder and their binding to the top level.
module tgarle_checker import tgarle_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_valid,
    input logic     o_ready,
    input t_pix_in  i_pix,
    input logic     i_cfg_we,
    input logic     i_cfg_wdata,
    input logic     o_valid,
    input logic     i_ready,
    input t_pix_out o_res
);

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_res))
        else $error("result changed while stalled");

    // The last result of a row also closes its packet.
    a_row_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.row_end |-> o_res.packet_end)
        else $error("row end without packet end");

    // Only the first result of a packet carries a header.
    a_hdr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_res.packet_start |-> o_res.header_byte == 8'h00)
        else $error("header on a non-opening result");

    // Repeat packets and one-pixel packets are a single result.
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.packet_start &&
        (o_res.header_byte[7] || o_res.header_byte[6:0] == 7'd0) |-> o_res.packet_end)
        else $error("single-result packet not closed");

endmodule

bind tga_rle_row_encoder tgarle_checker u_checker (.*);
